[hw/rtl/lwc_pkg.sv]
// shared types and constants for the local window correlation core
`default_nettype none
package lwc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int ADDR_W     = 11;
    localparam int LINE_DEPTH = 2 * MAX_WIDTH;
    localparam int LINE_W     = 16;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PWIN,
        S_EMIT1,
        S_EMIT2,
        S_FRD,
        S_FEMIT
    } t_top_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_ACC,
        M_VAR,
        M_MUL,
        M_DIV,
        M_SQRT,
        M_DONE
    } t_math_state;

    typedef struct packed {
        logic [71:0]      ref_win;
        logic [71:0]      dep_win;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_corr_req;

endpackage
`default_nettype wire

[hw/rtl/local_window_correlation_core.sv]
// local 3x3 pearson correlation core: line store, window and control
// order: in the cycle after a pixel beat is taken, the line store data is in and the window
//   updates; each result then passes through the correlation unit's accumulate, variance,
//   multiply, divide, square root and output steps (divide and root skipped on zero variance)
// flow: no new input beat is taken until the results of the last one are handed to the
//   single divide and root unit, which takes a new result only once it has output the last one
// reset: synchronous active low; clears counters, flush state and handshakes, width 640 and
//   height 480; the line store is not cleared and is only read after this frame wrote it
`default_nettype none
module local_window_correlation_core
    import lwc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_action,
    input  wire logic [7:0]          i_ref_pixel,
    input  wire logic [7:0]          i_depth_pixel,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic signed [15:0]       o_corr_value,
    output logic                     o_zero_variance,
    output logic [ROW_W-1:0]         o_out_row,
    output logic [COL_W-1:0]         o_out_col,
    output logic                     o_frame_last
);

    t_top_state r_state, n_state;

    logic [FW_W-1:0]  r_fw, n_fw;
    logic [FH_W-1:0]  r_fh, n_fh;
    logic [COL_W-1:0] r_col, n_col, r_flush_col, n_flush_col, r_ecol, n_ecol;
    logic [ROW_W-1:0] r_row, n_row, r_erow, n_erow;
    logic             r_flush_pend, n_flush_pend;
    logic             r_emit1, n_emit1, r_emit2, n_emit2;
    logic [1:0]       r_fk, n_fk;
    logic [7:0]       r_nr, n_nr, r_nd, n_nd;
    logic [7:0]       r_wr [9];
    logic [7:0]       n_wr [9];
    logic [7:0]       r_wd [9];
    logic [7:0]       n_wd [9];

    logic             in_acc, cfg_wr;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [FW_W-1:0]  eff_w;
    logic [FH_W-1:0]  eff_h;
    logic [10:0]      ctmp, cdec;
    logic [COL_W-1:0] fcol;
    logic [1:0]       cap_k;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_ra, ram_rb;
    logic [LINE_W-1:0] ram_wdata, ram_da, ram_db;

    logic      m_start, m_ready;
    t_corr_req m_req;
    logic [7:0] sel_r [9];
    logic [7:0] sel_d [9];
    logic [7:0] col_r [3];
    logic [7:0] col_d [3];

    assign in_acc = i_in_valid && !o_in_stall;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? {19'b0, r_fh} : {21'b0, r_fw};

    always_comb begin
        eff_w = r_fw;
        if (r_fw < 11'd2) eff_w = 11'd2;
        if (r_fw > 11'(MAX_WIDTH)) eff_w = 11'(MAX_WIDTH);
        eff_h = r_fh;
        if (r_fh < 13'd2) eff_h = 13'd2;
        if (r_fh > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
    end
    assign wm1 = COL_W'(eff_w - 11'd1);
    assign hm1 = ROW_W'(eff_h - 13'd1);

    // flush reads column flush_col + k - 1, replicated at both borders
    assign ctmp = {1'b0, r_flush_col} + {9'b0, r_fk};
    assign cdec = (ctmp == 11'd0) ? 11'd0 : ctmp - 11'd1;
    assign fcol = (cdec > {1'b0, wm1}) ? wm1 : cdec[COL_W-1:0];
    assign cap_k = r_fk - 2'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_action) n_state = r_flush_pend ? S_FRD : S_IDLE;
                    else          n_state = r_flush_pend ? S_IDLE : S_PWIN;
                end
            end
            S_PWIN:  n_state = S_EMIT1;
            S_EMIT1: if (!r_emit1 || m_ready) n_state = S_EMIT2;
            S_EMIT2: if (!r_emit2 || m_ready) n_state = S_IDLE;
            S_FRD:   if (r_fk == 2'd3) n_state = S_FEMIT;
            S_FEMIT: if (m_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_fw = r_fw; n_fh = r_fh; n_col = r_col; n_row = r_row;
        n_flush_col = r_flush_col; n_flush_pend = r_flush_pend;
        n_ecol = r_ecol; n_erow = r_erow; n_emit1 = r_emit1; n_emit2 = r_emit2;
        n_fk = r_fk; n_nr = r_nr; n_nd = r_nd;
        n_wr = r_wr; n_wd = r_wd;
        sel_r = r_wr; sel_d = r_wd;
        o_in_stall = 1'b1;
        ram_we = 1'b0;
        ram_waddr = {r_row[0], r_col};
        ram_wdata = {r_nr, r_nd};
        ram_ra = {r_row[0], r_col};
        ram_rb = {~r_row[0], r_col};
        m_start = 1'b0;
        m_req.row = r_erow;
        m_req.col = r_ecol;
        m_req.last = 1'b0;

        col_r[1] = ram_db[15:8];
        col_d[1] = ram_db[7:0];
        col_r[0] = (r_row >= 12'd2) ? ram_da[15:8] : ram_db[15:8];
        col_d[0] = (r_row >= 12'd2) ? ram_da[7:0]  : ram_db[7:0];
        col_r[2] = r_nr;
        col_d[2] = r_nd;

        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (in_acc) begin
                    n_nr = i_ref_pixel;
                    n_nd = i_depth_pixel;
                    n_fk = '0;
                end
            end
            S_PWIN: begin
                ram_we = 1'b1;
                if (r_row != '0) begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_col == '0) begin
                            n_wr[k] = col_r[k]; n_wr[3+k] = col_r[k];
                            n_wd[k] = col_d[k]; n_wd[3+k] = col_d[k];
                        end else begin
                            n_wr[k] = r_wr[3+k]; n_wr[3+k] = r_wr[6+k];
                            n_wd[k] = r_wd[3+k]; n_wd[3+k] = r_wd[6+k];
                        end
                        n_wr[6+k] = col_r[k];
                        n_wd[6+k] = col_d[k];
                    end
                end
                n_emit1 = (r_row != '0) && (r_col != '0);
                n_emit2 = (r_row != '0) && (r_col == wm1);
                n_erow  = r_row - 12'd1;
                n_ecol  = r_col - 10'd1;
                if (r_col >= wm1) begin
                    n_col = '0;
                    if (r_row >= hm1) begin
                        n_flush_pend = 1'b1;
                        n_flush_col  = '0;
                    end else begin
                        n_row = r_row + 12'd1;
                    end
                end else begin
                    n_col = r_col + 10'd1;
                end
            end
            S_EMIT1: begin
                m_start = r_emit1 && m_ready;
            end
            S_EMIT2: begin
                // last column: window slides once more with the right column replicated
                for (int k = 0; k < 3; k++) begin
                    sel_r[k] = r_wr[3+k]; sel_r[3+k] = r_wr[6+k];
                    sel_d[k] = r_wd[3+k]; sel_d[3+k] = r_wd[6+k];
                end
                m_req.col = wm1;
                m_start = r_emit2 && m_ready;
                if (m_start) begin
                    n_wr = sel_r;
                    n_wd = sel_d;
                end
            end
            S_FRD: begin
                ram_ra = {r_row[0], fcol};
                ram_rb = {~r_row[0], fcol};
                n_fk = r_fk + 2'd1;
                if (r_fk != 2'd0) begin
                    for (int k = 0; k < 3; k++) begin
                        if (cap_k == 2'(k)) begin
                            n_wr[3*k]   = ram_db[15:8];
                            n_wd[3*k]   = ram_db[7:0];
                            n_wr[3*k+1] = ram_da[15:8];
                            n_wd[3*k+1] = ram_da[7:0];
                            n_wr[3*k+2] = ram_da[15:8];
                            n_wd[3*k+2] = ram_da[7:0];
                        end
                    end
                end
            end
            S_FEMIT: begin
                m_req.row  = r_row;
                m_req.col  = r_flush_col;
                m_req.last = (r_flush_col == wm1);
                m_start = m_ready;
                if (m_ready) begin
                    if (r_flush_col >= wm1) begin
                        n_col = '0; n_row = '0; n_flush_col = '0; n_flush_pend = 1'b0;
                    end else begin
                        n_flush_col = r_flush_col + 10'd1;
                    end
                end
            end
            default: ;
        endcase

        if (cfg_wr) begin
            if (paddr[2] == REG_FRAME_WIDTH) n_fw = pwdata[FW_W-1:0];
            else                             n_fh = pwdata[FH_W-1:0];
            n_col = '0; n_row = '0; n_flush_col = '0; n_flush_pend = 1'b0;
        end

        for (int k = 0; k < 9; k++) begin
            m_req.ref_win[8*k +: 8] = sel_r[k];
            m_req.dep_win[8*k +: 8] = sel_d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fw <= FW_RESET;
            r_fh <= FH_RESET;
            r_col <= '0;
            r_row <= '0;
            r_flush_col <= '0;
            r_flush_pend <= 1'b0;
            r_emit1 <= 1'b0;
            r_emit2 <= 1'b0;
            r_fk <= '0;
            for (int k = 0; k < 9; k++) begin
                r_wr[k] <= '0;
                r_wd[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_fw <= n_fw;
            r_fh <= n_fh;
            r_col <= n_col;
            r_row <= n_row;
            r_flush_col <= n_flush_col;
            r_flush_pend <= n_flush_pend;
            r_emit1 <= n_emit1;
            r_emit2 <= n_emit2;
            r_fk <= n_fk;
            r_wr <= n_wr;
            r_wd <= n_wd;
        end
        r_ecol <= n_ecol;
        r_erow <= n_erow;
        r_nr <= n_nr;
        r_nd <= n_nd;
    end

    lwc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_ra),
        .i_raddr_b (ram_rb),
        .o_rdata_a (ram_da),
        .o_rdata_b (ram_db)
    );

    lwc_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m_start),
        .i_req   (m_req),
        .o_ready (m_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_corr  (o_corr_value),
        .o_zero  (o_zero_variance),
        .o_row   (o_out_row),
        .o_col   (o_out_col),
        .o_last  (o_frame_last)
    );

`ifndef SYNTHESIS
    a_start_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_start |-> m_ready)
        else $error("correlation unit started while busy");
    a_pend_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush_pend |-> (r_col == '0))
        else $error("flush pending with column count not at zero");
    a_flush_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush_pend |-> (r_flush_col <= wm1))
        else $error("flush column beyond row end");
`endif

endmodule
`default_nettype wire

[hw/rtl/lwc_ram.sv]
// generic ram, one write port, two registered read ports
`default_nettype none
module lwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

[hw/rtl/lwc_corr.sv]
// window sums, variance products, long division and square root for one result
`default_nettype none
module lwc_corr
    import lwc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_corr_req         i_req,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic signed [15:0]     o_corr,
    output logic                   o_zero,
    output logic [ROW_W-1:0]       o_row,
    output logic [COL_W-1:0]       o_col,
    output logic                   o_last
);

    t_math_state r_state, n_state;

    logic [71:0]      r_xw, n_xw, r_yw, n_yw;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_last, n_last;
    logic [4:0]       r_cnt, n_cnt;
    logic [11:0]      r_sx, n_sx, r_sy, n_sy;
    logic [19:0]      r_sxx, n_sxx, r_syy, n_syy, r_sxy, n_sxy;
    logic [22:0]      r_vx, n_vx, r_vy, n_vy, r_aabs, n_aabs;
    logic             r_neg, n_neg, r_zero, n_zero;
    logic [45:0]      r_p, n_p;
    logic [46:0]      r_rem, n_rem;
    logic [30:0]      r_q, n_q;
    logic [31:0]      r_x, n_x, r_res, n_res, r_bit, n_bit;
    logic             r_ovalid, n_ovalid;
    logic [15:0]      r_ocorr, n_ocorr;
    logic             r_ozero, n_ozero;
    logic [ROW_W-1:0] r_orow, n_orow;
    logic [COL_W-1:0] r_ocol, n_ocol;
    logic             r_olast, n_olast;

    logic             out_free;
    logic [7:0]       px, py;
    logic [23:0]      s9xx, s9yy, s9xy, sx2, sy2, sxsy;
    logic [24:0]      vx_full, vy_full, a_full, a_mag;
    logic [46:0]      div_diff;
    logic             div_ge;
    logic [30:0]      q_next;
    logic [31:0]      sq_sum;
    logic             sq_ge;
    logic [16:0]      m_sum;
    logic [15:0]      m_val;

    assign out_free = !r_ovalid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            M_IDLE: if (i_start) n_state = M_ACC;
            M_ACC:  if (r_cnt == 5'd8) n_state = M_VAR;
            M_VAR:  n_state = M_MUL;
            M_MUL:  n_state = r_zero ? M_DONE : M_DIV;
            M_DIV:  if (r_cnt == 5'd30) n_state = M_SQRT;
            M_SQRT: if (r_cnt == 5'd15) n_state = M_DONE;
            M_DONE: if (out_free) n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_xw = r_xw;   n_yw = r_yw;   n_row = r_row; n_col = r_col; n_last = r_last;
        n_cnt = r_cnt; n_sx = r_sx;   n_sy = r_sy;
        n_sxx = r_sxx; n_syy = r_syy; n_sxy = r_sxy;
        n_vx = r_vx;   n_vy = r_vy;   n_aabs = r_aabs; n_neg = r_neg; n_zero = r_zero;
        n_p = r_p;     n_rem = r_rem; n_q = r_q;
        n_x = r_x;     n_res = r_res; n_bit = r_bit;
        n_ovalid = r_ovalid && i_stall;
        n_ocorr = r_ocorr; n_ozero = r_ozero; n_orow = r_orow;
        n_ocol = r_ocol;   n_olast = r_olast;

        px   = r_xw[7:0];
        py   = r_yw[7:0];
        s9xx = {1'b0, r_sxx, 3'b0} + {4'b0, r_sxx};
        s9yy = {1'b0, r_syy, 3'b0} + {4'b0, r_syy};
        s9xy = {1'b0, r_sxy, 3'b0} + {4'b0, r_sxy};
        sx2  = r_sx * r_sx;
        sy2  = r_sy * r_sy;
        sxsy = r_sx * r_sy;
        vx_full = {1'b0, s9xx} - {1'b0, sx2};
        vy_full = {1'b0, s9yy} - {1'b0, sy2};
        a_full  = {1'b0, s9xy} - {1'b0, sxsy};
        a_mag   = a_full[24] ? (25'd0 - a_full) : a_full;

        div_ge   = r_rem >= {1'b0, r_p};
        div_diff = r_rem - {1'b0, r_p};
        q_next   = {r_q[29:0], div_ge};

        sq_sum = r_res + r_bit;
        sq_ge  = r_x >= sq_sum;

        // round to nearest: the largest odd 2m-1 not above the square root of the scaled ratio
        m_sum = {1'b0, r_res[15:0]} + 17'd1;
        m_val = m_sum[16:1];

        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_xw = i_req.ref_win; n_yw = i_req.dep_win;
                    n_row = i_req.row; n_col = i_req.col; n_last = i_req.last;
                    n_sx = '0; n_sy = '0; n_sxx = '0; n_syy = '0; n_sxy = '0;
                    n_cnt = '0;
                end
            end
            M_ACC: begin
                n_sx  = r_sx + {4'b0, px};
                n_sy  = r_sy + {4'b0, py};
                n_sxx = r_sxx + {4'b0, 16'(px) * 16'(px)};
                n_syy = r_syy + {4'b0, 16'(py) * 16'(py)};
                n_sxy = r_sxy + {4'b0, 16'(px) * 16'(py)};
                n_xw  = {8'b0, r_xw[71:8]};
                n_yw  = {8'b0, r_yw[71:8]};
                n_cnt = r_cnt + 5'd1;
            end
            M_VAR: begin
                n_vx   = vx_full[22:0];
                n_vy   = vy_full[22:0];
                n_aabs = a_mag[22:0];
                n_neg  = a_full[24];
                n_zero = vx_full[24] || (vx_full == '0) || vy_full[24] || (vy_full == '0);
            end
            M_MUL: begin
                n_p   = r_vx * r_vy;
                n_rem = {1'b0, 46'(r_aabs) * 46'(r_aabs)};
                n_q   = '0;
                n_cnt = '0;
            end
            M_DIV: begin
                n_rem = {(div_ge ? div_diff[45:0] : r_rem[45:0]), 1'b0};
                n_q   = q_next;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    n_x   = {1'b0, q_next};
                    n_res = '0;
                    n_bit = 32'h4000_0000;
                    n_cnt = '0;
                end
            end
            M_SQRT: begin
                n_x   = sq_ge ? (r_x - sq_sum) : r_x;
                n_res = sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 5'd1;
            end
            M_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ozero  = r_zero;
                    n_ocorr  = r_zero ? 16'd0 : (r_neg ? (16'd0 - m_val) : m_val);
                    n_orow   = r_row;
                    n_ocol   = r_col;
                    n_olast  = r_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= M_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_xw <= n_xw;   r_yw <= n_yw;   r_row <= n_row; r_col <= n_col; r_last <= n_last;
        r_cnt <= n_cnt; r_sx <= n_sx;   r_sy <= n_sy;
        r_sxx <= n_sxx; r_syy <= n_syy; r_sxy <= n_sxy;
        r_vx <= n_vx;   r_vy <= n_vy;   r_aabs <= n_aabs; r_neg <= n_neg; r_zero <= n_zero;
        r_p <= n_p;     r_rem <= n_rem; r_q <= n_q;
        r_x <= n_x;     r_res <= n_res; r_bit <= n_bit;
        r_ocorr <= n_ocorr; r_ozero <= n_ozero; r_orow <= n_orow;
        r_ocol <= n_ocol;   r_olast <= n_olast;
    end

    assign o_ready = (r_state == M_IDLE);
    assign o_valid = r_ovalid;
    assign o_corr  = $signed(r_ocorr);
    assign o_zero  = r_ozero;
    assign o_row   = r_orow;
    assign o_col   = r_ocol;
    assign o_last  = r_olast;

`ifndef SYNTHESIS
    a_zero_forces_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ozero) |-> (r_ocorr == 16'd0))
        else $error("zero variance result with nonzero value");
    a_corr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ($signed(r_ocorr) <= 16'sd16384 && $signed(r_ocorr) >= -16'sd16384))
        else $error("correlation out of range");
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == M_DIV) |-> (r_rem < {r_p, 1'b0}))
        else $error("division remainder out of bound");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
// testbench for the local window correlation core: directed and random frames checked against a predictor
`default_nettype none
module tb_top;
    import lwc_pkg::*;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;
    localparam int   WATCHDOG_LIMIT = 40000;
    localparam int   SETTLE_CYCLES  = 300;
    localparam int   RANDOM_ITEMS   = 800;

    typedef struct {
        logic       action;
        logic [7:0] ref_px;
        logic [7:0] dep_px;
        bit         drain;
    } t_pixel_beat;

    typedef struct {
        logic signed [15:0] corr;
        logic               zero_var;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               last;
    } t_corr_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    wire logic [31:0]  prdata;
    wire logic         pready;
    logic              i_in_valid = 1'b0;
    wire logic         o_in_stall;
    logic              i_action = ACT_PIXEL;
    logic [7:0]        i_ref_pixel = '0;
    logic [7:0]        i_depth_pixel = '0;
    wire logic         o_out_valid;
    logic              i_out_stall = 1'b0;
    wire logic signed [15:0] o_corr_value;
    wire logic         o_zero_variance;
    wire logic [ROW_W-1:0] o_out_row;
    wire logic [COL_W-1:0] o_out_col;
    wire logic         o_frame_last;

    local_window_correlation_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_action(i_action),
        .i_ref_pixel(i_ref_pixel), .i_depth_pixel(i_depth_pixel),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_corr_value(o_corr_value), .o_zero_variance(o_zero_variance),
        .o_out_row(o_out_row), .o_out_col(o_out_col), .o_frame_last(o_frame_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_pixel_beat  pixel_q[$];
    t_corr_result corr_q[$];
    int           errors = 0;
    int           idle_cycles = 0;
    bit           in_calm = 1'b0;
    bit           out_calm = 1'b0;
    int           random_sent = 0;

    // predictor state
    logic [7:0]   ref_line[LINE_DEPTH];
    logic [7:0]   dep_line[LINE_DEPTH];
    logic [7:0]   win[18];   // [img*9 + col*3 + row]
    int           col_cnt, row_cnt, flush_c;
    bit           flush_pend;
    int           cfg_width, cfg_height;

    function automatic int pick_gap(input bit calm);
        int x;
        x = $urandom_range(0, 99);
        if (calm || x < 55) return 0;
        if (x < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_width();
        return (cfg_width < 2) ? 2 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    endfunction

    function automatic int eff_height();
        return (cfg_height < 2) ? 2 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
    endfunction

    task automatic restart_frame();
        col_cnt = 0;
        row_cnt = 0;
        flush_c = 0;
        flush_pend = 1'b0;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // exact pearson value over one window, rounded, 16384 = 1.0
    task automatic push_corr(input logic [7:0] r[9], input logic [7:0] d[9],
                             input int row, input int col, input bit last);
        longint sx, sy, sxx, syy, sxy, a, vx, vy, x, y;
        logic [127:0] p, a2, t, rhs;
        int lo, hi, m, k;
        t_corr_result e;
        sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        for (k = 0; k < 9; k++) begin
            x = r[k];
            y = d[k];
            sx += x; sy += y; sxx += x * x; syy += y * y; sxy += x * y;
        end
        a  = 9 * sxy - sx * sy;
        vx = 9 * sxx - sx * sx;
        vy = 9 * syy - sy * sy;
        e.corr = '0;
        e.zero_var = 1'b0;
        if (vx <= 0 || vy <= 0) begin
            e.zero_var = 1'b1;
        end else begin
            p   = 128'(vx) * 128'(vy);
            a2  = 128'(a < 0 ? -a : a);
            a2  = a2 * a2;
            rhs = a2 << 30;
            lo = 0;
            hi = 16384;
            while (lo < hi) begin
                m = (lo + hi + 1) / 2;
                t = 128'(2 * m - 1);
                t = t * t;
                if (t * p <= rhs) lo = m;
                else hi = m - 1;
            end
            e.corr = (a < 0) ? -16'(lo) : 16'(lo);
        end
        e.row  = row[ROW_W-1:0];
        e.col  = col[COL_W-1:0];
        e.last = last;
        corr_q.push_back(e);
    endtask

    task automatic predict_beat(input t_pixel_beat it);
        logic [7:0] r[9], d[9], col_r[3], col_d[3];
        int w, h, cb, ob, c, k, cur, prv;
        w = eff_width();
        h = eff_height();
        if (it.action == ACT_FLUSH) begin
            if (!flush_pend) return;
            cb = (row_cnt % 2) * MAX_WIDTH;
            ob = ((row_cnt + 1) % 2) * MAX_WIDTH;
            for (k = 0; k < 3; k++) begin
                c = flush_c + k;
                c = (c == 0) ? 0 : c - 1;
                if (c > w - 1) c = w - 1;
                r[k*3] = ref_line[ob + c];
                d[k*3] = dep_line[ob + c];
                r[k*3+1] = ref_line[cb + c];
                r[k*3+2] = ref_line[cb + c];
                d[k*3+1] = dep_line[cb + c];
                d[k*3+2] = dep_line[cb + c];
            end
            push_corr(r, d, row_cnt, flush_c, flush_c == w - 1);
            if (flush_c >= w - 1) restart_frame();
            else flush_c++;
            return;
        end
        if (flush_pend) return;
        cur = (row_cnt % 2) * MAX_WIDTH + col_cnt;
        prv = ((row_cnt + 1) % 2) * MAX_WIDTH + col_cnt;
        if (row_cnt >= 1) begin
            col_r[1] = ref_line[prv];
            col_d[1] = dep_line[prv];
            col_r[0] = (row_cnt >= 2) ? ref_line[cur] : col_r[1];
            col_d[0] = (row_cnt >= 2) ? dep_line[cur] : col_d[1];
            col_r[2] = it.ref_px;
            col_d[2] = it.dep_px;
            for (k = 0; k < 3; k++) begin
                if (col_cnt == 0) begin
                    win[k] = col_r[k]; win[3+k] = col_r[k]; win[6+k] = col_r[k];
                    win[9+k] = col_d[k]; win[12+k] = col_d[k]; win[15+k] = col_d[k];
                end else begin
                    win[k] = win[3+k]; win[3+k] = win[6+k]; win[6+k] = col_r[k];
                    win[9+k] = win[12+k]; win[12+k] = win[15+k]; win[15+k] = col_d[k];
                end
            end
            if (col_cnt >= 1) begin
                for (k = 0; k < 9; k++) begin
                    r[k] = win[k];
                    d[k] = win[9+k];
                end
                push_corr(r, d, row_cnt - 1, col_cnt - 1, 1'b0);
            end
            if (col_cnt == w - 1) begin
                // right border: shift once more, last column replicated
                for (k = 0; k < 3; k++) begin
                    win[k] = win[3+k]; win[3+k] = win[6+k];
                    win[9+k] = win[12+k]; win[12+k] = win[15+k];
                end
                for (k = 0; k < 9; k++) begin
                    r[k] = win[k];
                    d[k] = win[9+k];
                end
                push_corr(r, d, row_cnt - 1, w - 1, 1'b0);
            end
        end
        ref_line[cur] = it.ref_px;
        dep_line[cur] = it.dep_px;
        if (col_cnt >= w - 1) begin
            col_cnt = 0;
            if (row_cnt >= h - 1) begin
                flush_pend = 1'b1;
                flush_c = 0;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
    endtask

    // input side
    t_pixel_beat cur_beat;
    int          in_gap = 0;
    bit          in_busy;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            in_busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_beat(cur_beat);
                in_busy = 1'b0;
                in_gap = pick_gap(in_calm);
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pixel_q.size() > 0 &&
                             !(pixel_q[0].drain && corr_q.size() != 0)) begin
                    cur_beat = pixel_q.pop_front();
                    i_action <= cur_beat.action;
                    i_ref_pixel <= cur_beat.ref_px;
                    i_depth_pixel <= cur_beat.dep_px;
                    in_busy = 1'b1;
                end
            end
            i_in_valid <= in_busy;
        end
    end

    // output side
    int           out_gap = 0;
    t_corr_result want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (corr_q.size() == 0) begin
                    report("unexpected result at col", o_out_col, -1);
                end else begin
                    want = corr_q.pop_front();
                    if (o_corr_value !== want.corr) report("corr_value", o_corr_value, want.corr);
                    if (o_zero_variance !== want.zero_var)
                        report("zero_variance", o_zero_variance, want.zero_var);
                    if (o_out_row !== want.row) report("out_row", o_out_row, want.row);
                    if (o_out_col !== want.col) report("out_col", o_out_col, want.col);
                    if (o_frame_last !== want.last)
                        report("frame_last", o_frame_last, want.last);
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) out_gap = pick_gap(out_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(input logic index, input int value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * index);
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (index == REG_FRAME_WIDTH) cfg_width = value & 32'h7ff;
        else cfg_height = value & 32'h1fff;
        restart_frame();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || i_in_valid || corr_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_beat(input logic act, input logic [7:0] r, input logic [7:0] d,
                             input bit drain, input bit counted);
        t_pixel_beat b;
        b.action = act;
        b.ref_px = r;
        b.dep_px = d;
        b.drain = drain;
        pixel_q.push_back(b);
        if (counted) random_sent++;
    endtask

    // content styles: random, flat reference, equal, inverted, extremes, narrow range
    task automatic push_frame(input int w, input int h, input int rows, input int style,
                              input bit drain_first, input bit noisy);
        int rr, cc, k;
        logic [7:0] r, d;
        for (rr = 0; rr < rows; rr++) begin
            for (cc = 0; cc < w; cc++) begin
                r = $urandom;
                d = $urandom;
                case (style)
                    1: r = 8'd77;
                    2: d = r;
                    3: d = ~r;
                    4: begin
                        r = {8{r[0]}};
                        d = {8{d[0]}};
                    end
                    5: begin
                        r = r & 8'h03;
                        d = d & 8'h03;
                    end
                    default: ;
                endcase
                // stray flush while streaming is ignored
                if (noisy && $urandom_range(0, 49) == 0)
                    push_beat(ACT_FLUSH, $urandom, $urandom, 1'b0, 1'b0);
                push_beat(ACT_PIXEL, r, d, drain_first && rr == 0 && cc == 0, 1'b1);
            end
        end
        if (rows < h) return;
        // pixels while the last row is pending are ignored
        if (noisy && $urandom_range(0, 4) == 0)
            push_beat(ACT_PIXEL, $urandom, $urandom, 1'b0, 1'b0);
        for (k = 0; k < w; k++) push_beat(ACT_FLUSH, $urandom, $urandom, 1'b0, 1'b1);
        if (noisy && $urandom_range(0, 4) == 0)
            push_beat(ACT_FLUSH, $urandom, $urandom, 1'b0, 1'b0);
    endtask

    int w_set, h_set, nfr, f;
    initial begin
        foreach (win[k]) win[k] = '0;
        cfg_width = FW_RESET;
        cfg_height = FH_RESET;
        restart_frame();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 3x3 frames, flush with nothing pending, extremes, flat window
        reg_write(REG_FRAME_WIDTH, 3);
        reg_write(REG_FRAME_HEIGHT, 3);
        push_beat(ACT_FLUSH, 8'hff, 8'hff, 1'b0, 1'b0);
        push_frame(3, 3, 3, 4, 1'b1, 1'b1);
        push_frame(3, 3, 3, 1, 1'b0, 1'b0);
        wait_idle();

        // below the minimum, clamped to 2x2
        reg_write(REG_FRAME_WIDTH, 0);
        reg_write(REG_FRAME_HEIGHT, 1);
        push_frame(2, 2, 2, 2, 1'b0, 1'b0);
        push_frame(2, 2, 2, 3, 1'b0, 1'b1);
        wait_idle();

        // widest row and tallest frame, partial frame then restart
        reg_write(REG_FRAME_WIDTH, 2047);
        reg_write(REG_FRAME_HEIGHT, 8191);
        push_frame(MAX_WIDTH, MAX_HEIGHT, 1, 0, 1'b0, 1'b0);
        push_beat(ACT_PIXEL, 8'h00, 8'hff, 1'b0, 1'b0);
        push_beat(ACT_PIXEL, 8'hff, 8'h00, 1'b0, 1'b0);
        push_beat(ACT_PIXEL, 8'h5a, 8'ha5, 1'b0, 1'b0);
        wait_idle();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            w_set = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
            h_set = $urandom_range(2, 6);
            in_calm = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) begin
                reg_write(REG_FRAME_HEIGHT, h_set);
                reg_write(REG_FRAME_WIDTH, w_set);
            end else begin
                reg_write(REG_FRAME_WIDTH, w_set);
                reg_write(REG_FRAME_HEIGHT, h_set);
            end
            nfr = $urandom_range(1, 3);
            for (f = 0; f < nfr; f++) begin
                push_frame(w_set, h_set,
                           ($urandom_range(0, 9) == 0) ? $urandom_range(1, h_set) : h_set,
                           ($urandom_range(0, 1)) ? 0 : $urandom_range(1, 5),
                           $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
